// ===== design/ev_charger_sequence_fsm_defines.svh =====
// Assertion helpers shared by the charger sequence design.
`ifndef EV_CHARGER_SEQUENCE_FSM_DEFINES_SVH
`define EV_CHARGER_SEQUENCE_FSM_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ECS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ecs check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ECS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ecs check failed");

`endif

// ===== design/ecs_pkg.sv =====
`default_nettype none

package ecs_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned DELAY_W = 16;
   localparam int unsigned PHASE_W = 4;

   localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(100);

   // Charging sequence phases, coded as seen on the result channel.
   typedef enum logic [PHASE_W-1:0] {
      PH_STARTUP  = 4'd0,
      PH_CHECK_SW = 4'd1,
      PH_U120     = 4'd2,
      PH_CHG120   = 4'd3,
      PH_B2       = 4'd4,
      PH_C2       = 4'd5,
      PH_U240     = 4'd6,
      PH_CHG240   = 4'd7,
      PH_ERROR    = 4'd8
   } phase_type;

   // One tick request as held in the input register.
   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              ok_120;
      logic              switched_120;
      logic              switched_240;
      logic              evse_b2_ready;
      logic              evse_c2_ready;
      logic              ok_240;
      logic              shutdown_d_high;
      logic              clear_error_request;
   } req_item_type;

endpackage

`default_nettype wire

// ===== design/ev_charger_sequence_fsm.sv =====
// Charging sequence controller. Each accepted request is one tick carrying a
// millisecond timestamp and eight condition bits; each tick yields exactly one
// response with the phase after that tick, the held shutdown and start-charge
// levels, and a one-tick timer restart pulse on entry to charging 240 V.
// Throughput is one request per clock cycle while the response side does not
// stall, set by the loop through the phase register, the wrapping 32-bit
// elapsed-time subtract and the compare against the configured delay. A taken
// request waits in the input register until the response register is free or
// drained; its response is then loaded into the response register. A stalled
// response holds off new requests only once the input register is also
// occupied. The delay register resets to 100 ms and should be written only
// while no requests are in flight.
`default_nettype none

`include "ev_charger_sequence_fsm_defines.svh"

module ev_charger_sequence_fsm (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [ecs_pkg::TIME_W-1:0]     req_now_ms,
   input  wire logic                           req_ok_120,
   input  wire logic                           req_switched_120,
   input  wire logic                           req_switched_240,
   input  wire logic                           req_evse_b2_ready,
   input  wire logic                           req_evse_c2_ready,
   input  wire logic                           req_ok_240,
   input  wire logic                           req_shutdown_d_high,
   input  wire logic                           req_clear_error_request,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [ecs_pkg::PHASE_W-1:0]         rsp_phase,
   output logic                                rsp_sw_shutdown,
   output logic                                rsp_charge_enable,
   output logic                                rsp_restart_timer_pulse,
   input  wire logic                           csr_wr_en,
   input  wire logic [ecs_pkg::DELAY_W-1:0]    csr_wr_data
);

   ecs_pkg::req_item_type             req_item_ff;
   logic                              req_vld_ff;
   logic                              rsp_vld_ff;
   logic [ecs_pkg::PHASE_W-1:0]       rsp_phase_ff;
   logic                              rsp_shutdown_ff;
   logic                              rsp_charge_ff;
   logic                              rsp_pulse_ff;
   logic [ecs_pkg::DELAY_W-1:0]       delay_ff;
   ecs_pkg::phase_type                phase_ff;
   ecs_pkg::phase_type                phase_in;
   logic [ecs_pkg::TIME_W-1:0]        last_change_ff;
   logic [ecs_pkg::TIME_W-1:0]        last_change_in;
   logic                              shutdown_ff;
   logic                              shutdown_in;
   logic                              charge_ff;
   logic                              charge_in;
   logic                              pulse_in;
   logic                              change;
   logic                              advance;
   logic [ecs_pkg::TIME_W-1:0]        elapsed;
   logic                              waiting;

   // The held request moves on when the response register is free or drained.
   assign advance   = req_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !req_vld_ff || advance;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= ecs_pkg::DELAY_RESET;
      end else if (csr_wr_en) begin
         delay_ff <= csr_wr_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_ready) begin
         req_vld_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         req_item_ff.now_ms              <= req_now_ms;
         req_item_ff.ok_120              <= req_ok_120;
         req_item_ff.switched_120        <= req_switched_120;
         req_item_ff.switched_240        <= req_switched_240;
         req_item_ff.evse_b2_ready       <= req_evse_b2_ready;
         req_item_ff.evse_c2_ready       <= req_evse_c2_ready;
         req_item_ff.ok_240              <= req_ok_240;
         req_item_ff.shutdown_d_high     <= req_shutdown_d_high;
         req_item_ff.clear_error_request <= req_clear_error_request;
      end
   end

   // Wrapping elapsed time since the last phase change.
   assign elapsed = req_item_ff.now_ms - last_change_ff;
   assign waiting = elapsed < {{(ecs_pkg::TIME_W - ecs_pkg::DELAY_W){1'b0}}, delay_ff};

   // Next phase. Only the 120 V unlatched and charging phases skip the delay.
   always_comb begin
      phase_in = phase_ff;
      change   = 1'b0;
      case (phase_ff)
         ecs_pkg::PH_STARTUP: begin
            if (!waiting) begin
               change   = 1'b1;
               phase_in = req_item_ff.ok_120 ? ecs_pkg::PH_CHECK_SW : ecs_pkg::PH_ERROR;
            end
         end
         ecs_pkg::PH_CHECK_SW: begin
            // With both selector bits set, 120 V wins.
            if (!waiting) begin
               if (!req_item_ff.ok_120) begin
                  change   = 1'b1;
                  phase_in = ecs_pkg::PH_ERROR;
               end else if (req_item_ff.switched_120) begin
                  change   = 1'b1;
                  phase_in = ecs_pkg::PH_U120;
               end else if (req_item_ff.switched_240) begin
                  change   = 1'b1;
                  phase_in = ecs_pkg::PH_B2;
               end
            end
         end
         ecs_pkg::PH_U120: begin
            if (!req_item_ff.ok_120 || !req_item_ff.switched_120) begin
               change   = 1'b1;
               phase_in = ecs_pkg::PH_ERROR;
            end else if (req_item_ff.shutdown_d_high) begin
               change   = 1'b1;
               phase_in = ecs_pkg::PH_CHG120;
            end
         end
         ecs_pkg::PH_CHG120: begin
            if (!req_item_ff.ok_120 || !req_item_ff.switched_120) begin
               change   = 1'b1;
               phase_in = ecs_pkg::PH_ERROR;
            end
         end
         ecs_pkg::PH_B2: begin
            if (!waiting && req_item_ff.evse_b2_ready) begin
               change   = 1'b1;
               phase_in = ecs_pkg::PH_C2;
            end
         end
         ecs_pkg::PH_C2: begin
            if (!waiting) begin
               if (!req_item_ff.ok_240) begin
                  change   = 1'b1;
                  phase_in = ecs_pkg::PH_ERROR;
               end else if (req_item_ff.evse_c2_ready) begin
                  change   = 1'b1;
                  phase_in = ecs_pkg::PH_U240;
               end
            end
         end
         ecs_pkg::PH_U240: begin
            if (!waiting) begin
               if (!req_item_ff.evse_c2_ready || !req_item_ff.ok_240) begin
                  change   = 1'b1;
                  phase_in = ecs_pkg::PH_ERROR;
               end else if (req_item_ff.shutdown_d_high) begin
                  change   = 1'b1;
                  phase_in = ecs_pkg::PH_CHG240;
               end
            end
         end
         ecs_pkg::PH_CHG240: begin
            if (!waiting && (!req_item_ff.evse_c2_ready || !req_item_ff.ok_240)) begin
               change   = 1'b1;
               phase_in = ecs_pkg::PH_ERROR;
            end
         end
         ecs_pkg::PH_ERROR: begin
            if (!waiting && req_item_ff.clear_error_request) begin
               change   = 1'b1;
               phase_in = ecs_pkg::PH_STARTUP;
            end
         end
         default: begin
            phase_in = phase_ff;
            change   = 1'b0;
         end
      endcase
   end

   // Exit and entry actions on a phase change.
   always_comb begin
      shutdown_in    = shutdown_ff;
      charge_in      = charge_ff;
      pulse_in       = 1'b0;
      last_change_in = last_change_ff;
      if (change) begin
         last_change_in = req_item_ff.now_ms;
         if (phase_ff == ecs_pkg::PH_B2) begin
            charge_in = 1'b1;
         end
         if (phase_in inside {ecs_pkg::PH_U120, ecs_pkg::PH_U240}) begin
            shutdown_in = 1'b1;
         end
         if (phase_in == ecs_pkg::PH_CHG240) begin
            pulse_in = 1'b1;
         end
         if (phase_in == ecs_pkg::PH_ERROR) begin
            shutdown_in = 1'b0;
            charge_in   = 1'b0;
         end
      end
   end

   // Sequence state, updated once per processed request.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= ecs_pkg::PH_STARTUP;
         last_change_ff <= '0;
         shutdown_ff    <= 1'b0;
         charge_ff      <= 1'b0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         last_change_ff <= last_change_in;
         shutdown_ff    <= shutdown_in;
         charge_ff      <= charge_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (advance) begin
         rsp_phase_ff    <= phase_in;
         rsp_shutdown_ff <= shutdown_in;
         rsp_charge_ff   <= charge_in;
         rsp_pulse_ff    <= pulse_in;
      end
   end

   assign rsp_valid               = rsp_vld_ff;
   assign rsp_phase               = rsp_phase_ff;
   assign rsp_sw_shutdown         = rsp_shutdown_ff;
   assign rsp_charge_enable       = rsp_charge_ff;
   assign rsp_restart_timer_pulse = rsp_pulse_ff;

   // The restart pulse only accompanies charging 240 V.
   `ECS_ASSERT_NOW(a_pulse_phase, clock, reset,
      rsp_valid && rsp_restart_timer_pulse, rsp_phase == ecs_pkg::PH_CHG240)

   // In the error phase both held levels are off.
   `ECS_ASSERT_NOW(a_error_levels, clock, reset,
      rsp_valid && (rsp_phase == ecs_pkg::PH_ERROR), !rsp_sw_shutdown && !rsp_charge_enable)

   // The change timestamp only moves when the phase changes.
   `ECS_ASSERT_NEXT(a_stamp_hold, clock, reset,
      !(advance && change), $stable(last_change_ff))

endmodule

`default_nettype wire

// ===== tb/ev_charger_sequence_checker.sv =====
// Watches both channels of the charging sequence controller, keeps its own
// model of the sequence and compares every response with the oldest
// expectation.
module ev_charger_sequence_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_ready,
   input  wire logic [ecs_pkg::TIME_W-1:0]  req_now_ms,
   input  wire logic                        req_ok_120,
   input  wire logic                        req_switched_120,
   input  wire logic                        req_switched_240,
   input  wire logic                        req_evse_b2_ready,
   input  wire logic                        req_evse_c2_ready,
   input  wire logic                        req_ok_240,
   input  wire logic                        req_shutdown_d_high,
   input  wire logic                        req_clear_error_request,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire logic [ecs_pkg::PHASE_W-1:0] rsp_phase,
   input  wire logic                        rsp_sw_shutdown,
   input  wire logic                        rsp_charge_enable,
   input  wire logic                        rsp_restart_timer_pulse,
   input  wire logic                        csr_wr_en,
   input  wire logic [ecs_pkg::DELAY_W-1:0] csr_wr_data,
   output int unsigned                      mismatch_count,
   output int unsigned                      outstanding_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // One response as seen on the result channel.
   typedef struct packed {
      ecs_pkg::phase_type phase;
      logic               sw_shutdown;
      logic               charge_enable;
      logic               restart_pulse;
   } status_type;

   // Model state of the sequence and its delay register.
   ecs_pkg::phase_type          seq_phase;
   logic [ecs_pkg::TIME_W-1:0]  last_change_ms;
   logic                        shutdown_lvl;
   logic                        charge_lvl;
   logic [ecs_pkg::DELAY_W-1:0] delay_ms;

   status_type expected_status_q[$];

   // Advances the model by one tick and returns the response it should give.
   function automatic status_type predict_status(input ecs_pkg::req_item_type tick);
      logic [ecs_pkg::TIME_W-1:0] elapsed;
      logic                       waiting;
      logic                       moving;
      logic                       pulse;
      ecs_pkg::phase_type         target;
      status_type                 result;
      elapsed = tick.now_ms - last_change_ms;
      waiting = elapsed < (ecs_pkg::TIME_W)'(delay_ms);
      moving = 1'b0;
      pulse = 1'b0;
      target = seq_phase;

      // Choose the next phase; only the two 120 V phases ignore the delay.
      case (seq_phase)
         ecs_pkg::PH_STARTUP: begin
            if (!waiting) begin
               moving = 1'b1;
               target = tick.ok_120 ? ecs_pkg::PH_CHECK_SW : ecs_pkg::PH_ERROR;
            end
         end
         ecs_pkg::PH_CHECK_SW: begin
            if (!waiting) begin
               if (!tick.ok_120) begin
                  moving = 1'b1;
                  target = ecs_pkg::PH_ERROR;
               end else if (tick.switched_120) begin
                  moving = 1'b1;
                  target = ecs_pkg::PH_U120;
               end else if (tick.switched_240) begin
                  moving = 1'b1;
                  target = ecs_pkg::PH_B2;
               end
            end
         end
         ecs_pkg::PH_U120: begin
            if (!tick.ok_120 || !tick.switched_120) begin
               moving = 1'b1;
               target = ecs_pkg::PH_ERROR;
            end else if (tick.shutdown_d_high) begin
               moving = 1'b1;
               target = ecs_pkg::PH_CHG120;
            end
         end
         ecs_pkg::PH_CHG120: begin
            if (!tick.ok_120 || !tick.switched_120) begin
               moving = 1'b1;
               target = ecs_pkg::PH_ERROR;
            end
         end
         ecs_pkg::PH_B2: begin
            if (!waiting && tick.evse_b2_ready) begin
               moving = 1'b1;
               target = ecs_pkg::PH_C2;
            end
         end
         ecs_pkg::PH_C2: begin
            if (!waiting) begin
               if (!tick.ok_240) begin
                  moving = 1'b1;
                  target = ecs_pkg::PH_ERROR;
               end else if (tick.evse_c2_ready) begin
                  moving = 1'b1;
                  target = ecs_pkg::PH_U240;
               end
            end
         end
         ecs_pkg::PH_U240: begin
            if (!waiting) begin
               if (!tick.evse_c2_ready || !tick.ok_240) begin
                  moving = 1'b1;
                  target = ecs_pkg::PH_ERROR;
               end else if (tick.shutdown_d_high) begin
                  moving = 1'b1;
                  target = ecs_pkg::PH_CHG240;
               end
            end
         end
         ecs_pkg::PH_CHG240: begin
            if (!waiting && (!tick.evse_c2_ready || !tick.ok_240)) begin
               moving = 1'b1;
               target = ecs_pkg::PH_ERROR;
            end
         end
         ecs_pkg::PH_ERROR: begin
            if (!waiting && tick.clear_error_request) begin
               moving = 1'b1;
               target = ecs_pkg::PH_STARTUP;
            end
         end
         default: begin
         end
      endcase

      // Exit and entry actions of a phase change.
      if (moving) begin
         if (seq_phase == ecs_pkg::PH_B2) begin
            charge_lvl = 1'b1;
         end
         case (target)
            ecs_pkg::PH_U120, ecs_pkg::PH_U240: begin
               shutdown_lvl = 1'b1;
            end
            ecs_pkg::PH_CHG240: begin
               pulse = 1'b1;
            end
            ecs_pkg::PH_ERROR: begin
               shutdown_lvl = 1'b0;
               charge_lvl = 1'b0;
            end
            default: begin
            end
         endcase
         seq_phase = target;
         last_change_ms = tick.now_ms;
      end

      result.phase = seq_phase;
      result.sw_shutdown = shutdown_lvl;
      result.charge_enable = charge_lvl;
      result.restart_pulse = pulse;
      return result;
   endfunction

   // Counts a failure and reports the first few of them.
   task automatic log_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   // Everything happens on the rising edge, where the channels are stable.
   always @(posedge clock) begin
      status_type want;
      status_type got;
      if (reset) begin
         seq_phase = ecs_pkg::PH_STARTUP;
         last_change_ms = '0;
         shutdown_lvl = 1'b0;
         charge_lvl = 1'b0;
         delay_ms = ecs_pkg::DELAY_RESET;
         expected_status_q.delete();
      end else begin
         // Compare an accepted response with the oldest expectation.
         if (rsp_valid && rsp_ready) begin
            got.phase = ecs_pkg::phase_type'(rsp_phase);
            got.sw_shutdown = rsp_sw_shutdown;
            got.charge_enable = rsp_charge_enable;
            got.restart_pulse = rsp_restart_timer_pulse;
            if (expected_status_q.size() == 0) begin
               log_failure($sformatf("response with nothing expected: phase %0d", rsp_phase));
            end else begin
               want = expected_status_q.pop_front();
               if (got !== want) begin
                  log_failure($sformatf({"mismatch: expected phase %0d shutdown %b",
                     " charge %b pulse %b, got phase %0d shutdown %b charge %b pulse %b"},
                     want.phase, want.sw_shutdown, want.charge_enable, want.restart_pulse,
                     rsp_phase, rsp_sw_shutdown, rsp_charge_enable, rsp_restart_timer_pulse));
               end
            end
         end

         // Every accepted request yields exactly one response.
         if (req_valid && req_ready) begin
            expected_status_q.push_back(predict_status({req_now_ms, req_ok_120,
               req_switched_120, req_switched_240, req_evse_b2_ready, req_evse_c2_ready,
               req_ok_240, req_shutdown_d_high, req_clear_error_request}));
         end

         if (csr_wr_en) begin
            delay_ms = csr_wr_data;
         end
      end
      outstanding_count = expected_status_q.size();
   end

endmodule

// ===== tb/tb_ev_charger_sequence_fsm.sv =====
// Stimulus and verdict for the charging sequence controller. The checker
// beside the block does all prediction and comparison.
module tb_ev_charger_sequence_fsm;
   timeunit 1ns;
   timeprecision 1ps;

   // Condition bits in the order they follow the timestamp in a request.
   localparam logic [7:0] C_OK120 = 8'h80;
   localparam logic [7:0] C_SW120 = 8'h40;
   localparam logic [7:0] C_SW240 = 8'h20;
   localparam logic [7:0] C_B2    = 8'h10;
   localparam logic [7:0] C_C2    = 8'h08;
   localparam logic [7:0] C_OK240 = 8'h04;
   localparam logic [7:0] C_LATCH = 8'h02;
   localparam logic [7:0] C_CLEAR = 8'h01;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned TICKS_PER_ROUND = 320;

   // Kinds of condition streams used by the random part.
   typedef enum logic [1:0] {
      RUN_120,
      RUN_240,
      RUN_NOISE
   } stim_mode_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   ecs_pkg::req_item_type       req_tick = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [ecs_pkg::PHASE_W-1:0] rsp_phase;
   logic                        rsp_sw_shutdown;
   logic                        rsp_charge_enable;
   logic                        rsp_restart_timer_pulse;
   logic                        csr_wr_en = 1'b0;
   logic [ecs_pkg::DELAY_W-1:0] csr_wr_data = '0;

   int unsigned mismatch_count;
   int unsigned outstanding_count;
   int unsigned cycle_count = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned stall_pct = 0;

   // Stimulus state: running millisecond clock, current delay and stream kind.
   logic [ecs_pkg::TIME_W-1:0]  ms_clock = '0;
   logic [ecs_pkg::DELAY_W-1:0] cur_delay = ecs_pkg::DELAY_RESET;
   stim_mode_type               stim_mode = RUN_120;
   int unsigned                 mode_left = 0;

   ev_charger_sequence_fsm dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_now_ms              (req_tick.now_ms),
      .req_ok_120              (req_tick.ok_120),
      .req_switched_120        (req_tick.switched_120),
      .req_switched_240        (req_tick.switched_240),
      .req_evse_b2_ready       (req_tick.evse_b2_ready),
      .req_evse_c2_ready       (req_tick.evse_c2_ready),
      .req_ok_240              (req_tick.ok_240),
      .req_shutdown_d_high     (req_tick.shutdown_d_high),
      .req_clear_error_request (req_tick.clear_error_request),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_phase               (rsp_phase),
      .rsp_sw_shutdown         (rsp_sw_shutdown),
      .rsp_charge_enable       (rsp_charge_enable),
      .rsp_restart_timer_pulse (rsp_restart_timer_pulse),
      .csr_wr_en               (csr_wr_en),
      .csr_wr_data             (csr_wr_data)
   );

   ev_charger_sequence_checker check_inst (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_now_ms              (req_tick.now_ms),
      .req_ok_120              (req_tick.ok_120),
      .req_switched_120        (req_tick.switched_120),
      .req_switched_240        (req_tick.switched_240),
      .req_evse_b2_ready       (req_tick.evse_b2_ready),
      .req_evse_c2_ready       (req_tick.evse_c2_ready),
      .req_ok_240              (req_tick.ok_240),
      .req_shutdown_d_high     (req_tick.shutdown_d_high),
      .req_clear_error_request (req_tick.clear_error_request),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_phase               (rsp_phase),
      .rsp_sw_shutdown         (rsp_sw_shutdown),
      .rsp_charge_enable       (rsp_charge_enable),
      .rsp_restart_timer_pulse (rsp_restart_timer_pulse),
      .csr_wr_en               (csr_wr_en),
      .csr_wr_data             (csr_wr_data),
      .mismatch_count          (mismatch_count),
      .outstanding_count       (outstanding_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // The response side stalls at random at the current rate.
   always @(negedge clock) begin
      rsp_ready <= !($urandom_range(0, 99) < stall_pct);
   end

   // Ends a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_ev_charger_sequence_fsm failed");
         $finish;
      end
   end

   // Offers one request, possibly after an idle gap, and returns at the
   // falling edge after it was accepted with valid still high.
   task automatic send_tick(input ecs_pkg::req_item_type tick);
      int unsigned gap;
      gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_tick <= tick;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Waits with the sender quiet until every expected response has come.
   task automatic wait_drained();
      while (outstanding_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_delay(input logic [ecs_pkg::DELAY_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Builds a random request: the timestamp moves mostly in steps around the
   // delay, sometimes jumps anywhere; condition bits follow the stream kind.
   function automatic ecs_pkg::req_item_type make_tick();
      int unsigned                pick;
      logic [ecs_pkg::TIME_W-1:0] step;
      logic [7:0]                 flags;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         step = $urandom_range(0, 2 * cur_delay + 2);
      end else if (pick < 80) begin
         step = $urandom_range(0, 3);
      end else if (pick < 95) begin
         step = (pick % 2) ? (ecs_pkg::TIME_W)'(cur_delay)
                           : (ecs_pkg::TIME_W)'(cur_delay) - 1;
      end else begin
         step = $urandom();
      end
      ms_clock = ms_clock + step;

      flags = 8'($urandom());
      case (stim_mode)
         RUN_120: begin
            flags = flags | C_OK120 | C_SW120;
         end
         RUN_240: begin
            flags = (flags | C_OK120 | C_SW240 | C_C2 | C_OK240) & ~C_SW120;
         end
         default: begin
         end
      endcase
      // Occasional broken condition to knock the sequence into error.
      if ($urandom_range(0, 99) < 5) begin
         flags = flags ^ (8'd1 << $urandom_range(0, 7));
      end
      return {ms_clock, flags};
   endfunction

   initial begin
      int unsigned round_idx;
      int unsigned n;
      int unsigned pick;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed walk through both charging paths at the reset delay.
      send_tick({32'd50, C_OK120});
      send_tick({32'd100, C_OK120});
      send_tick({32'd150, C_OK120 | C_SW120 | C_SW240});
      send_tick({32'd200, C_OK120 | C_SW120 | C_SW240});
      send_tick({32'd201, C_OK120 | C_SW120});
      send_tick({32'd202, C_OK120 | C_SW120 | C_LATCH});
      send_tick({32'd203, C_OK120 | C_SW120});
      send_tick({32'd204, C_OK120});
      send_tick({32'd250, C_CLEAR});
      send_tick({32'd304, 8'h00});
      send_tick({32'd305, C_CLEAR});
      send_tick({32'd405, C_SW120});
      send_tick({32'd505, C_CLEAR});
      send_tick({32'd605, C_OK120});
      send_tick({32'd705, C_OK120 | C_SW240});
      send_tick({32'd805, C_OK240 | C_C2});
      send_tick({32'd806, C_B2});
      send_tick({32'd906, C_OK240});
      send_tick({32'd907, C_OK240 | C_C2});
      send_tick({32'd1007, C_OK240 | C_C2 | C_LATCH});
      send_tick({32'd1107, C_OK240 | C_C2});
      send_tick({32'd1207, C_OK240});
      // Timestamp moving backwards counts as a long wait.
      send_tick({32'd0, C_CLEAR});
      send_tick({32'hFFFF_FFFF, 8'hFF});
      // Elapsed time across the wrap lands exactly on the delay.
      send_tick({32'h0000_0063, 8'hFF});
      ms_clock = 32'h0000_0063;

      // Random rounds, each with its own delay and idling pattern.
      for (round_idx = 0; round_idx < 4; round_idx++) begin
         req_valid <= 1'b0;
         wait_drained();
         case (round_idx)
            0: begin
               cur_delay = 16'd0;
               sender_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               cur_delay = 16'd65535;
               sender_idle_pct = 60;
               stall_pct = 0;
            end
            2: begin
               cur_delay = 16'd3;
               sender_idle_pct = 0;
               stall_pct = 60;
               ms_clock = 32'hFFFF_FF00;
            end
            default: begin
               cur_delay = 16'd250;
               sender_idle_pct = 36;
               stall_pct = 36;
            end
         endcase
         write_delay(cur_delay);

         for (n = 0; n < TICKS_PER_ROUND; n++) begin
            // In the last round, hold off the sender once mid-round until the pipeline is empty.
            if (round_idx == 3 && n == TICKS_PER_ROUND / 2) begin
               req_valid <= 1'b0;
               wait_drained();
            end
            if (mode_left == 0) begin
               pick = $urandom_range(0, 99);
               stim_mode = (pick < 45) ? RUN_120 : (pick < 90) ? RUN_240 : RUN_NOISE;
               mode_left = $urandom_range(10, 40);
            end
            mode_left--;
            send_tick(make_tick());
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb_ev_charger_sequence_fsm passed");
      end else begin
         $display("tb_ev_charger_sequence_fsm failed");
      end
      $finish;
   end

endmodule
